### hw/rtl/rwpe_pkg.sv
// rwpe_pkg: shared types and constants for the riff/wave pcm extractor
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package rwpe_pkg;

    // chunk and header tags, big-endian as they arrive
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    // format expectations
    localparam logic [15:0] FMT_PCM  = 16'h0001;
    localparam logic [15:0] PCM_BITS = 16'd16;
    localparam logic [4:0]  FMT_KEEP = 5'd20;

    // result kinds
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // header result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOT_WAVE = 3'd1;
    localparam logic [2:0] ST_NO_PAIR  = 3'd2;
    localparam logic [2:0] ST_NOT_PCM  = 3'd3;
    localparam logic [2:0] ST_NOT_16   = 3'd4;

    // parser phases
    typedef enum logic [6:0] {
        PH_RIFF    = 7'b000_0001,
        PH_CHDR    = 7'b000_0010,
        PH_FMT     = 7'b000_0100,
        PH_SKIP    = 7'b000_1000,
        PH_PAD     = 7'b001_0000,
        PH_PAYLOAD = 7'b010_0000,
        PH_WAIT    = 7'b100_0000
    } phase_t;

    // one input word
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
        logic       abort;
    } in_word_t;

    // one result word
    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic [15:0] audio_format;
        logic [15:0] channel_count;
        logic [31:0] rate_hz;
        logic [15:0] sample_bits;
        logic [31:0] data_length;
        logic [7:0]  payload_byte;
        logic        final_res;
    } result_t;

endpackage

### hw/rtl/rwpe_in_stage.sv
// rwpe_in_stage: input register of the extractor
// depends on rwpe_pkg for the input word type
`timescale 1ns / 1ps

module rwpe_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rwpe_pkg::in_word_t in_word,
    input  logic              advance,
    output logic              word_valid,
    output rwpe_pkg::in_word_t word
);

    logic               valid_reg;
    logic               valid_next;
    rwpe_pkg::in_word_t word_reg;

    // accept when empty or when the held word moves on this cycle
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload holding register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= in_word;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

### hw/rtl/rwpe_parser.sv
// rwpe_parser: chunk walker state and per-word decision logic
// depends on rwpe_pkg for phases, tags, status codes and word types
`timescale 1ns / 1ps

module rwpe_parser
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  rwpe_pkg::in_word_t word,
    output logic               res_valid,
    output rwpe_pkg::result_t  res
);

    rwpe_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  hdr_count_reg, hdr_count_next;
    logic [31:0] chunk_tag_reg, chunk_tag_next;
    logic [31:0] chunk_length_reg, chunk_length_next;
    logic [31:0] skip_reg, skip_next;
    logic        pad_reg, pad_next;
    logic [4:0]  fmt_count_reg, fmt_count_next;
    logic [15:0] format_reg, format_next;
    logic [15:0] channels_reg, channels_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic        fmt_found_reg, fmt_found_next;
    logic [31:0] payload_rem_reg, payload_rem_next;

    // where to go once a chunk body is done
    function automatic rwpe_pkg::phase_t body_done(input logic [31:0] skip, input logic pad);
        rwpe_pkg::phase_t ph;
        if (skip != 32'd0)
        begin
            ph = rwpe_pkg::PH_SKIP;
        end
        else if (pad)
        begin
            ph = rwpe_pkg::PH_PAD;
        end
        else
        begin
            ph = rwpe_pkg::PH_CHDR;
        end
        return ph;
    endfunction

    // bytes of fmt worth keeping for a given chunk size
    function automatic logic [4:0] fmt_want(input logic [31:0] len);
        logic [4:0] w;
        if (len < {27'd0, rwpe_pkg::FMT_KEEP})
        begin
            w = len[4:0];
        end
        else
        begin
            w = rwpe_pkg::FMT_KEEP;
        end
        return w;
    endfunction

    logic [7:0]  b;
    logic [31:0] tag_shift;
    logic [31:0] len_v;
    logic [31:0] tag_v;
    logic [2:0]  k_hdr;
    logic [4:0]  want_v;
    logic [5:0]  fmt_inc;
    logic [31:0] dec_v;
    logic [2:0]  st_v;
    logic        start_hdr;
    logic        produce;
    logic        fin;

    assign b         = word.in_byte;
    assign tag_shift = {chunk_tag_reg[23:0], b};
    assign k_hdr     = hdr_count_reg[2:0];

    // next state and result for the word in hand
    always_comb
    begin
        phase_next        = phase_reg;
        hdr_count_next    = hdr_count_reg;
        chunk_tag_next    = chunk_tag_reg;
        chunk_length_next = chunk_length_reg;
        skip_next         = skip_reg;
        pad_next          = pad_reg;
        fmt_count_next    = fmt_count_reg;
        format_next       = format_reg;
        channels_next     = channels_reg;
        rate_next         = rate_reg;
        bits_next         = bits_reg;
        fmt_found_next    = fmt_found_reg;
        payload_rem_next  = payload_rem_reg;
        len_v             = chunk_length_reg;
        tag_v             = chunk_tag_reg;
        want_v            = fmt_want(chunk_length_reg);
        fmt_inc           = {1'b0, fmt_count_reg} + 6'd1;
        dec_v             = 32'd0;
        st_v              = rwpe_pkg::ST_OK;
        start_hdr         = 1'b0;
        produce           = 1'b0;
        fin               = 1'b0;
        res               = '0;

        case (phase_reg)
            rwpe_pkg::PH_RIFF:
            begin
                chunk_tag_next = tag_shift;
                if ((hdr_count_reg == 4'd3 && tag_shift != rwpe_pkg::TAG_RIFF) ||
                    (hdr_count_reg == 4'd11 && tag_shift != rwpe_pkg::TAG_WAVE))
                begin
                    produce    = 1'b1;
                    fin        = 1'b1;
                    res.kind   = rwpe_pkg::KIND_HEADER;
                    res.status = rwpe_pkg::ST_NOT_WAVE;
                    phase_next = rwpe_pkg::PH_WAIT;
                end
                else if (hdr_count_reg >= 4'd11)
                begin
                    start_hdr = 1'b1;
                end
                else
                begin
                    hdr_count_next = hdr_count_reg + 4'd1;
                end
            end

            rwpe_pkg::PH_CHDR:
            begin
                // tag bytes first, then little-endian length
                if (k_hdr < 3'd4)
                begin
                    tag_v = tag_shift;
                end
                else
                begin
                    case (k_hdr[1:0])
                        2'd0:    len_v = chunk_length_reg | {24'd0, b};
                        2'd1:    len_v = chunk_length_reg | {16'd0, b, 8'd0};
                        2'd2:    len_v = chunk_length_reg | {8'd0, b, 16'd0};
                        default: len_v = chunk_length_reg | {b, 24'd0};
                    endcase
                end
                chunk_tag_next    = tag_v;
                chunk_length_next = len_v;
                if (k_hdr < 3'd7)
                begin
                    hdr_count_next = {1'b0, k_hdr + 3'd1};
                end
                else if (tag_v == rwpe_pkg::TAG_FMT)
                begin
                    want_v         = fmt_want(len_v);
                    format_next    = 16'd0;
                    channels_next  = 16'd0;
                    rate_next      = 32'd0;
                    bits_next      = 16'd0;
                    fmt_count_next = 5'd0;
                    skip_next      = len_v - {27'd0, want_v};
                    pad_next       = len_v[0];
                    if (want_v == 5'd0)
                    begin
                        fmt_found_next = 1'b1;
                        phase_next     = body_done(skip_next, pad_next);
                        start_hdr      = (phase_next == rwpe_pkg::PH_CHDR);
                    end
                    else
                    begin
                        phase_next = rwpe_pkg::PH_FMT;
                    end
                end
                else if (tag_v == rwpe_pkg::TAG_DATA)
                begin
                    produce    = 1'b1;
                    res.kind   = rwpe_pkg::KIND_HEADER;
                    if (!fmt_found_reg)
                    begin
                        fin        = 1'b1;
                        res.status = rwpe_pkg::ST_NO_PAIR;
                        phase_next = rwpe_pkg::PH_WAIT;
                    end
                    else
                    begin
                        if (format_reg != rwpe_pkg::FMT_PCM)
                        begin
                            st_v = rwpe_pkg::ST_NOT_PCM;
                        end
                        else if (bits_reg != rwpe_pkg::PCM_BITS)
                        begin
                            st_v = rwpe_pkg::ST_NOT_16;
                        end
                        payload_rem_next  = len_v;
                        res.status        = st_v;
                        res.audio_format  = format_reg;
                        res.channel_count = channels_reg;
                        res.rate_hz       = rate_reg;
                        res.sample_bits   = bits_reg;
                        res.data_length   = len_v;
                        if (st_v != rwpe_pkg::ST_OK || len_v == 32'd0)
                        begin
                            fin        = 1'b1;
                            phase_next = rwpe_pkg::PH_WAIT;
                        end
                        else
                        begin
                            phase_next = rwpe_pkg::PH_PAYLOAD;
                        end
                    end
                end
                else
                begin
                    // any other chunk is skipped whole
                    skip_next  = len_v;
                    pad_next   = len_v[0];
                    phase_next = body_done(skip_next, pad_next);
                    start_hdr  = (phase_next == rwpe_pkg::PH_CHDR);
                end
            end

            rwpe_pkg::PH_FMT:
            begin
                case (fmt_count_reg)
                    5'd0:    format_next   = format_reg | {8'd0, b};
                    5'd1:    format_next   = format_reg | {b, 8'd0};
                    5'd2:    channels_next = channels_reg | {8'd0, b};
                    5'd3:    channels_next = channels_reg | {b, 8'd0};
                    5'd4:    rate_next     = rate_reg | {24'd0, b};
                    5'd5:    rate_next     = rate_reg | {16'd0, b, 8'd0};
                    5'd6:    rate_next     = rate_reg | {8'd0, b, 16'd0};
                    5'd7:    rate_next     = rate_reg | {b, 24'd0};
                    5'd14:   bits_next     = bits_reg | {8'd0, b};
                    5'd15:   bits_next     = bits_reg | {b, 8'd0};
                    default: ;
                endcase
                fmt_count_next = fmt_inc[4:0];
                if (fmt_inc >= {1'b0, want_v})
                begin
                    fmt_found_next = 1'b1;
                    phase_next     = body_done(skip_reg, pad_reg);
                    start_hdr      = (phase_next == rwpe_pkg::PH_CHDR);
                end
            end

            rwpe_pkg::PH_SKIP:
            begin
                dec_v     = skip_reg - {31'd0, (skip_reg != 32'd0)};
                skip_next = dec_v;
                if (dec_v == 32'd0)
                begin
                    phase_next = body_done(dec_v, pad_reg);
                    start_hdr  = (phase_next == rwpe_pkg::PH_CHDR);
                end
            end

            rwpe_pkg::PH_PAD:
            begin
                pad_next   = 1'b0;
                phase_next = body_done(skip_reg, 1'b0);
                start_hdr  = (phase_next == rwpe_pkg::PH_CHDR);
            end

            rwpe_pkg::PH_PAYLOAD:
            begin
                if (word.abort)
                begin
                    phase_next = rwpe_pkg::PH_WAIT;
                end
                else
                begin
                    produce          = 1'b1;
                    res.kind         = rwpe_pkg::KIND_PAYLOAD;
                    res.payload_byte = b;
                    dec_v            = payload_rem_reg - {31'd0, (payload_rem_reg != 32'd0)};
                    payload_rem_next = dec_v;
                    if (dec_v == 32'd0)
                    begin
                        fin        = 1'b1;
                        phase_next = rwpe_pkg::PH_WAIT;
                    end
                end
            end

            default:
            begin
                phase_next = rwpe_pkg::PH_WAIT;
            end
        endcase

        // fresh chunk header
        if (start_hdr)
        begin
            phase_next        = rwpe_pkg::PH_CHDR;
            hdr_count_next    = 4'd0;
            chunk_tag_next    = 32'd0;
            chunk_length_next = 32'd0;
        end

        // end of file: close out the file and return to reset state
        if (word.last_byte)
        begin
            if (produce)
            begin
                fin = 1'b1;
            end
            else if (phase_next != rwpe_pkg::PH_WAIT)
            begin
                produce  = 1'b1;
                fin      = 1'b1;
                res      = '0;
                res.kind = rwpe_pkg::KIND_HEADER;
                if (phase_next == rwpe_pkg::PH_RIFF)
                begin
                    res.status = rwpe_pkg::ST_NOT_WAVE;
                end
                else
                begin
                    res.status = rwpe_pkg::ST_NO_PAIR;
                end
            end
            phase_next        = rwpe_pkg::PH_RIFF;
            hdr_count_next    = 4'd0;
            chunk_tag_next    = 32'd0;
            chunk_length_next = 32'd0;
            skip_next         = 32'd0;
            pad_next          = 1'b0;
            fmt_count_next    = 5'd0;
            format_next       = 16'd0;
            channels_next     = 16'd0;
            rate_next         = 32'd0;
            bits_next         = 16'd0;
            fmt_found_next    = 1'b0;
            payload_rem_next  = 32'd0;
        end

        res.final_res = fin;
    end

    assign res_valid = step && produce;

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= rwpe_pkg::PH_RIFF;
            hdr_count_reg    <= 4'd0;
            chunk_tag_reg    <= 32'd0;
            chunk_length_reg <= 32'd0;
            skip_reg         <= 32'd0;
            pad_reg          <= 1'b0;
            fmt_count_reg    <= 5'd0;
            format_reg       <= 16'd0;
            channels_reg     <= 16'd0;
            rate_reg         <= 32'd0;
            bits_reg         <= 16'd0;
            fmt_found_reg    <= 1'b0;
            payload_rem_reg  <= 32'd0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            hdr_count_reg    <= hdr_count_next;
            chunk_tag_reg    <= chunk_tag_next;
            chunk_length_reg <= chunk_length_next;
            skip_reg         <= skip_next;
            pad_reg          <= pad_next;
            fmt_count_reg    <= fmt_count_next;
            format_reg       <= format_next;
            channels_reg     <= channels_next;
            rate_reg         <= rate_next;
            bits_reg         <= bits_next;
            fmt_found_reg    <= fmt_found_next;
            payload_rem_reg  <= payload_rem_next;
        end
    end

endmodule

### hw/rtl/rwpe_out_stage.sv
// rwpe_out_stage: result register facing the receiver
// depends on rwpe_pkg for the result word type
`timescale 1ns / 1ps

module rwpe_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  rwpe_pkg::result_t res_in,
    output logic              can_take,
    output logic              out_valid,
    input  logic              out_ready,
    output rwpe_pkg::result_t res_out
);

    logic              valid_reg;
    logic              valid_next;
    rwpe_pkg::result_t res_reg;

    // free when empty or being drained this cycle
    assign can_take = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

### hw/rtl/riff_wave_pcm_extractor.sv
// riff_wave_pcm_extractor: top level of the byte-serial wav parser
// depends on rwpe_pkg, rwpe_in_stage, rwpe_parser and rwpe_out_stage
//
// Usage: a wav file is fed one byte per input word (in_byte), with last_byte
// set on the final byte of the file and abort available to cut payload output
// short. The block checks the RIFF/WAVE header, walks the chunk list, keeps
// the fmt fields and, on the data chunk, returns one header word (kind 0) with
// a status, followed by the data bytes as payload words (kind 1). final_res
// marks the last word for a file, unless abort cut its payload short; after
// last_byte the parser is back at the start of a new file.
// Both channels are valid/ready. An input word passes an input register, then
// the parser decision, then the output register. One byte is taken every
// cycle while the output side has room; words that give no result (header,
// skipped chunks) are consumed at the same rate. When the receiver stalls,
// the output register holds its word, the input register fills and in_ready
// drops; nothing is lost. Reset clears both registers and returns the parser
// to the expect-RIFF state.
`timescale 1ns / 1ps

module riff_wave_pcm_extractor
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        last_byte,
    input  logic        abort,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [2:0]  status,
    output logic [15:0] audio_format,
    output logic [15:0] channel_count,
    output logic [31:0] rate_hz,
    output logic [15:0] sample_bits,
    output logic [31:0] data_length,
    output logic [7:0]  payload_byte,
    output logic        final_res
);

    rwpe_pkg::in_word_t in_word;
    rwpe_pkg::in_word_t held_word;
    rwpe_pkg::result_t  res_new;
    rwpe_pkg::result_t  res_out;
    logic               held_valid;
    logic               out_free;
    logic               step;
    logic               res_valid;

    assign in_word.in_byte   = in_byte;
    assign in_word.last_byte = last_byte;
    assign in_word.abort     = abort;

    // a held byte moves through the parser when the output side has room
    assign step = held_valid && out_free;

    rwpe_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_word    (in_word),
        .advance    (step),
        .word_valid (held_valid),
        .word       (held_word)
    );

    rwpe_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .word      (held_word),
        .res_valid (res_valid),
        .res       (res_new)
    );

    rwpe_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res_in    (res_new),
        .can_take  (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_out   (res_out)
    );

    // result fields
    assign kind          = res_out.kind;
    assign status        = res_out.status;
    assign audio_format  = res_out.audio_format;
    assign channel_count = res_out.channel_count;
    assign rate_hz       = res_out.rate_hz;
    assign sample_bits   = res_out.sample_bits;
    assign data_length   = res_out.data_length;
    assign payload_byte  = res_out.payload_byte;
    assign final_res     = res_out.final_res;

endmodule
